// File: design/dwee_pkg.sv
// shared types, codes and constants for the dwarf expression evaluator
// no dependencies; used by dwee_exec and dwarf_expression_evaluator_unit
package dwee_pkg;

   localparam int DEF_STACK_DEPTH = 64;
   localparam int DEF_NUM_REGS    = 32;
   localparam int WORD_W          = 64;
   localparam int SHIFT_LIMIT     = 64;
   localparam int REQ_TDATA_W     = 144;
   localparam int RSP_TDATA_W     = 136;
   localparam int CSR_INDEX_W     = 2;

   // register index on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_BASE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_LIMIT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FINAL_DEREF  = 2'd2;

   typedef enum logic [1:0] {
      REQ_LOAD = 2'd0,
      REQ_OP   = 2'd1,
      REQ_DATA = 2'd2,
      REQ_END  = 2'd3
   } req_kind_type;

   typedef enum logic [3:0] {
      OP_AND         = 4'd0,
      OP_BREG        = 4'd1,
      OP_DEREF       = 4'd2,
      OP_GE          = 4'd3,
      OP_LIT         = 4'd4,
      OP_MUL         = 4'd5,
      OP_PLUS_UCONST = 4'd6,
      OP_PLUS        = 4'd7,
      OP_SHL         = 4'd8
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_FINAL = 2'd1,
      KIND_ERROR = 2'd2
   } result_kind_type;

   typedef enum logic [2:0] {
      ERR_UNDERFLOW   = 3'd0,
      ERR_OVERFLOW    = 3'd1,
      ERR_WINDOW      = 3'd2,
      ERR_UNSUPPORTED = 3'd3,
      ERR_BADREG      = 3'd4,
      ERR_DEPTH       = 3'd5,
      ERR_PROTOCOL    = 3'd6
   } error_code_type;

   // wait state, one-hot
   typedef enum logic [2:0] {
      WAIT_NONE  = 3'b001,
      WAIT_DEREF = 3'b010,
      WAIT_FINAL = 3'b100
   } wait_mode_type;

   typedef struct packed {
      logic [3:0]  opcode;
      logic [7:0]  reg_index;
      logic signed [31:0] reg_offset;
      logic [31:0] literal_value;
      logic [63:0] data_value;
   } item_type;

   typedef struct packed {
      wait_mode_type wait_mode;
      logic          err;
   } ctrl_type;

   typedef struct packed {
      logic            valid;
      result_kind_type kind;
      logic [63:0]     read_offset;
      logic [63:0]     final_value;
      error_code_type  error_code;
   } result_type;

endpackage

// File: design/dwarf_expression_evaluator_unit.sv
// path: a req transfer reaches its rsp through the input register, then the result register
// throughput: one item per cycle while the result stream is not stalled; every item runs in one pass through dwee_exec,
// with the top two stack entries in flops and the third read from the stack memory
// reset: synchronous, active high; clears the stack depth, wait state, error flag,
// config registers and register file valid bits; no clearing pass is needed
// depends on dwee_pkg and dwee_exec
module dwarf_expression_evaluator_unit #(
   parameter int STACK_DEPTH = dwee_pkg::DEF_STACK_DEPTH,
   parameter int NUM_REGS    = dwee_pkg::DEF_NUM_REGS
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration write port
   input  logic                                csr_wr_en,
   input  logic [dwee_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [63:0]                         csr_wdata,
   // request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // opcode[3:0], reg_index[11:4], reg_offset[43:12], literal_value[75:44],
   // data_value[139:76], zero pad
   input  logic [dwee_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // req_type[1:0]
   input  logic [1:0]                          req_tuser,
   // result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // read_offset[63:0], final_value[127:64], error_code[130:128], zero pad
   output logic [dwee_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // result_kind[1:0]
   output logic [1:0]                          rsp_tuser
);

   localparam int DW     = $clog2(STACK_DEPTH + 1);
   localparam int SA_W   = $clog2(STACK_DEPTH);
   localparam int RIDX_W = $clog2(NUM_REGS);

   // config registers
   logic [63:0] window_base_ff;
   logic [63:0] window_limit_ff;
   logic        final_deref_ff;

   // input stage
   logic                  s1_valid_ff;
   dwee_pkg::req_kind_type s1_kind_ff;
   dwee_pkg::item_type    s1_item_ff;
   dwee_pkg::item_type    req_item;
   logic                  req_xfer;
   logic                  exec_fire;

   // register file: memory plus valid bits, read when a request is taken
   logic [63:0]       rf_mem [NUM_REGS];
   logic [NUM_REGS-1:0] rf_valid_ff;
   logic [63:0]       rf_rd_ff;
   logic              rf_hit_ff;
   logic [RIDX_W-1:0] rf_raddr;
   logic              rf_bypass;
   logic [63:0]       rf_value;

   // stack: top and second in flops, deeper entries in memory
   logic [DW-1:0]     depth_ff;
   logic [63:0]       top_ff;
   logic [63:0]       second_ff;
   logic [63:0]       third_ff;
   logic [63:0]       stk_mem [STACK_DEPTH];
   logic [SA_W-1:0]   stk_raddr;
   dwee_pkg::ctrl_type ctrl_ff;

   // exec outputs
   logic [DW-1:0]        depth_in;
   logic [63:0]          top_in;
   logic [63:0]          second_in;
   dwee_pkg::ctrl_type   ctrl_in;
   logic                 stk_we;
   logic [SA_W-1:0]      stk_waddr;
   logic                 rf_we;
   logic [RIDX_W-1:0]    rf_waddr;
   dwee_pkg::result_type result;

   // result register
   logic                 rsp_valid_ff;
   dwee_pkg::result_type rsp_ff;

   // unpack the request transfer
   assign req_item.opcode        = req_tdata[3:0];
   assign req_item.reg_index     = req_tdata[11:4];
   assign req_item.reg_offset    = req_tdata[43:12];
   assign req_item.literal_value = req_tdata[75:44];
   assign req_item.data_value    = req_tdata[139:76];

   // item executes when the result register is free or being drained
   assign exec_fire  = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || exec_fire;
   assign req_xfer   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_base_ff  <= '0;
         window_limit_ff <= '0;
         final_deref_ff  <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            dwee_pkg::CSR_WINDOW_BASE:  window_base_ff  <= csr_wdata;
            dwee_pkg::CSR_WINDOW_LIMIT: window_limit_ff <= csr_wdata;
            dwee_pkg::CSR_FINAL_DEREF:  final_deref_ff  <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_kind_ff <= dwee_pkg::req_kind_type'(req_tuser);
         s1_item_ff <= req_item;
      end
   end

   // register file read with write-first bypass for a load leaving exec this cycle
   assign rf_raddr  = req_item.reg_index[RIDX_W-1:0];
   assign rf_bypass = exec_fire && rf_we && (rf_waddr == rf_raddr);
   assign rf_value  = rf_hit_ff ? rf_rd_ff : 64'd0;

   always_ff @(posedge clock) begin
      if (exec_fire && rf_we) begin
         rf_mem[rf_waddr] <= s1_item_ff.data_value;
      end
      if (req_xfer) begin
         rf_rd_ff <= rf_bypass ? s1_item_ff.data_value : rf_mem[rf_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_valid_ff <= '0;
         rf_hit_ff   <= 1'b0;
      end else begin
         if (exec_fire && rf_we) begin
            rf_valid_ff[rf_waddr] <= 1'b1;
         end
         if (req_xfer) begin
            rf_hit_ff <= rf_bypass || rf_valid_ff[rf_raddr];
         end
      end
   end

   dwee_exec #(
      .STACK_DEPTH (STACK_DEPTH),
      .NUM_REGS    (NUM_REGS)
   ) u_exec (
      .req_kind     (s1_kind_ff),
      .item         (s1_item_ff),
      .rf_value     (rf_value),
      .depth        (depth_ff),
      .top          (top_ff),
      .second       (second_ff),
      .third        (third_ff),
      .ctrl         (ctrl_ff),
      .window_base  (window_base_ff),
      .window_limit (window_limit_ff),
      .final_deref  (final_deref_ff),
      .depth_nx     (depth_in),
      .top_nx       (top_in),
      .second_nx    (second_in),
      .ctrl_nx      (ctrl_in),
      .stk_we       (stk_we),
      .stk_waddr    (stk_waddr),
      .rf_we        (rf_we),
      .rf_waddr     (rf_waddr),
      .result       (result)
   );

   // stack state
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         ctrl_ff  <= '{wait_mode: dwee_pkg::WAIT_NONE, err: 1'b0};
      end else if (exec_fire) begin
         depth_ff <= depth_in;
         ctrl_ff  <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_fire) begin
         top_ff    <= top_in;
         second_ff <= second_in;
      end
   end

   // third entry always prefetched for the next depth; a spill to that slot bypasses
   assign stk_raddr = SA_W'((exec_fire ? depth_in : depth_ff) - DW'(3));

   always_ff @(posedge clock) begin
      if (exec_fire && stk_we) begin
         stk_mem[stk_waddr] <= second_ff;
      end
      if (exec_fire && stk_we && (stk_waddr == stk_raddr)) begin
         third_ff <= second_ff;
      end else begin
         third_ff <= stk_mem[stk_raddr];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec_fire && result.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_fire && result.valid) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tdata  = {5'd0, rsp_ff.error_code, rsp_ff.final_value, rsp_ff.read_offset};

   // stack never grows past its capacity
   a_depth_range: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DW'(STACK_DEPTH))
      else $error("stack depth beyond capacity");

   // a latched error always drops any pending read
   a_wait_no_err: assert property (@(posedge clock) disable iff (reset)
      (ctrl_ff.wait_mode != dwee_pkg::WAIT_NONE) |-> !ctrl_ff.err)
      else $error("waiting for memory data with an error latched");

   // the final read leaves the stack empty
   a_final_wait_empty: assert property (@(posedge clock) disable iff (reset)
      (ctrl_ff.wait_mode == dwee_pkg::WAIT_FINAL) |-> (depth_ff == '0))
      else $error("final read pending with entries on the stack");

   // a new result only follows an executed item
   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      exec_fire && !result.valid && !rsp_valid_ff |=> !rsp_tvalid)
      else $error("result appeared without a producing item");

endmodule

// File: design/dwee_exec.sv
// single-item execute logic: next stack, control and register file writes plus result
// depends on dwee_pkg
module dwee_exec #(
   parameter int STACK_DEPTH = dwee_pkg::DEF_STACK_DEPTH,
   parameter int NUM_REGS    = dwee_pkg::DEF_NUM_REGS,
   localparam int DW         = $clog2(STACK_DEPTH + 1),
   localparam int SA_W       = $clog2(STACK_DEPTH),
   localparam int RIDX_W     = $clog2(NUM_REGS)
) (
   input  dwee_pkg::req_kind_type req_kind,
   input  dwee_pkg::item_type     item,
   input  logic [63:0]            rf_value,
   input  logic [DW-1:0]          depth,
   input  logic [63:0]            top,
   input  logic [63:0]            second,
   input  logic [63:0]            third,
   input  dwee_pkg::ctrl_type     ctrl,
   input  logic [63:0]            window_base,
   input  logic [63:0]            window_limit,
   input  logic                   final_deref,
   output logic [DW-1:0]          depth_nx,
   output logic [63:0]            top_nx,
   output logic [63:0]            second_nx,
   output dwee_pkg::ctrl_type     ctrl_nx,
   output logic                   stk_we,
   output logic [SA_W-1:0]        stk_waddr,
   output logic                   rf_we,
   output logic [RIDX_W-1:0]      rf_waddr,
   output dwee_pkg::result_type   result
);

   logic                     idx_ok;
   logic                     full;
   logic                     has1;
   logic                     has2;
   logic                     top_in_win;
   logic                     fail;
   dwee_pkg::error_code_type fail_code;
   logic [63:0]              breg_value;
   logic [63:0]              bin_value;

   assign idx_ok     = {1'b0, item.reg_index} < 9'(NUM_REGS);
   assign full       = depth >= DW'(STACK_DEPTH);
   assign has1       = depth >= DW'(1);
   assign has2       = depth >= DW'(2);
   assign top_in_win = (top >= window_base) && (top < window_limit);
   assign breg_value = rf_value + {{32{item.reg_offset[31]}}, item.reg_offset};
   assign stk_waddr  = SA_W'(depth - DW'(2));
   assign rf_waddr   = item.reg_index[RIDX_W-1:0];

   always_comb begin
      case (item.opcode)
         dwee_pkg::OP_AND: bin_value = top & second;
         dwee_pkg::OP_GE:  bin_value = {63'd0, second >= top};
         dwee_pkg::OP_PLUS: bin_value = top + second;
         dwee_pkg::OP_SHL: begin
            bin_value = (top >= 64'(dwee_pkg::SHIFT_LIMIT)) ? 64'd0 : (second << top[5:0]);
         end
         default: bin_value = top & second;
      endcase
   end

   always_comb begin
      depth_nx  = depth;
      top_nx    = top;
      second_nx = second;
      ctrl_nx   = ctrl;
      stk_we    = 1'b0;
      rf_we     = 1'b0;
      result    = '0;
      fail      = 1'b0;
      fail_code = dwee_pkg::ERR_UNDERFLOW;

      case (req_kind)
         dwee_pkg::REQ_LOAD: begin
            if (ctrl.err) begin
               rf_we = idx_ok;
            end else if (ctrl.wait_mode != dwee_pkg::WAIT_NONE) begin
               fail      = 1'b1;
               fail_code = dwee_pkg::ERR_PROTOCOL;
            end else if (!idx_ok) begin
               fail      = 1'b1;
               fail_code = dwee_pkg::ERR_BADREG;
            end else begin
               rf_we = 1'b1;
            end
         end
         dwee_pkg::REQ_OP: begin
            if (ctrl.err) begin
               // ignored until end
            end else if (ctrl.wait_mode != dwee_pkg::WAIT_NONE) begin
               fail      = 1'b1;
               fail_code = dwee_pkg::ERR_PROTOCOL;
            end else begin
               case (item.opcode)
                  dwee_pkg::OP_AND, dwee_pkg::OP_GE, dwee_pkg::OP_PLUS,
                  dwee_pkg::OP_SHL: begin
                     if (!has2) begin
                        fail      = 1'b1;
                        fail_code = dwee_pkg::ERR_UNDERFLOW;
                     end else begin
                        // pop: third entry moves up into second
                        top_nx    = bin_value;
                        second_nx = third;
                        depth_nx  = depth - DW'(1);
                     end
                  end
                  dwee_pkg::OP_BREG, dwee_pkg::OP_LIT: begin
                     if ((item.opcode == dwee_pkg::OP_BREG) && !idx_ok) begin
                        fail      = 1'b1;
                        fail_code = dwee_pkg::ERR_BADREG;
                     end else if (full) begin
                        fail      = 1'b1;
                        fail_code = dwee_pkg::ERR_OVERFLOW;
                     end else begin
                        // push: second spills into the stack memory
                        top_nx    = (item.opcode == dwee_pkg::OP_BREG) ? breg_value
                                                                      : {32'd0, item.literal_value};
                        second_nx = top;
                        stk_we    = has2;
                        depth_nx  = depth + DW'(1);
                     end
                  end
                  dwee_pkg::OP_DEREF: begin
                     if (!has1) begin
                        fail      = 1'b1;
                        fail_code = dwee_pkg::ERR_UNDERFLOW;
                     end else if (!top_in_win) begin
                        fail      = 1'b1;
                        fail_code = dwee_pkg::ERR_WINDOW;
                     end else begin
                        ctrl_nx.wait_mode  = dwee_pkg::WAIT_DEREF;
                        result.valid       = 1'b1;
                        result.kind        = dwee_pkg::KIND_READ;
                        result.read_offset = top - window_base;
                     end
                  end
                  dwee_pkg::OP_PLUS_UCONST: begin
                     if (!has1) begin
                        fail      = 1'b1;
                        fail_code = dwee_pkg::ERR_UNDERFLOW;
                     end else begin
                        top_nx = top + {32'd0, item.literal_value};
                     end
                  end
                  default: begin
                     // mul and undefined opcodes
                     fail      = 1'b1;
                     fail_code = dwee_pkg::ERR_UNSUPPORTED;
                  end
               endcase
            end
         end
         dwee_pkg::REQ_DATA: begin
            if (ctrl.err) begin
               // ignored until end
            end else if (ctrl.wait_mode == dwee_pkg::WAIT_DEREF) begin
               if (has1) begin
                  top_nx = item.data_value;
               end
               ctrl_nx.wait_mode = dwee_pkg::WAIT_NONE;
            end else if (ctrl.wait_mode == dwee_pkg::WAIT_FINAL) begin
               depth_nx           = '0;
               ctrl_nx.wait_mode  = dwee_pkg::WAIT_NONE;
               ctrl_nx.err        = 1'b0;
               result.valid       = 1'b1;
               result.kind        = dwee_pkg::KIND_FINAL;
               result.final_value = item.data_value;
            end else begin
               fail      = 1'b1;
               fail_code = dwee_pkg::ERR_PROTOCOL;
            end
         end
         dwee_pkg::REQ_END: begin
            // every end clears the expression unless it waits for the final read
            depth_nx          = '0;
            ctrl_nx.wait_mode = dwee_pkg::WAIT_NONE;
            ctrl_nx.err       = 1'b0;
            if (ctrl.err) begin
               // silent clear
            end else if (ctrl.wait_mode != dwee_pkg::WAIT_NONE) begin
               result.valid      = 1'b1;
               result.kind       = dwee_pkg::KIND_ERROR;
               result.error_code = dwee_pkg::ERR_PROTOCOL;
            end else if (depth != DW'(1)) begin
               result.valid      = 1'b1;
               result.kind       = dwee_pkg::KIND_ERROR;
               result.error_code = dwee_pkg::ERR_DEPTH;
            end else if (final_deref) begin
               if (!top_in_win) begin
                  result.valid      = 1'b1;
                  result.kind       = dwee_pkg::KIND_ERROR;
                  result.error_code = dwee_pkg::ERR_WINDOW;
               end else begin
                  ctrl_nx.wait_mode  = dwee_pkg::WAIT_FINAL;
                  result.valid       = 1'b1;
                  result.kind        = dwee_pkg::KIND_READ;
                  result.read_offset = top - window_base;
               end
            end else begin
               result.valid       = 1'b1;
               result.kind        = dwee_pkg::KIND_FINAL;
               result.final_value = top;
            end
         end
         default: begin
         end
      endcase

      if (fail) begin
         ctrl_nx.err       = 1'b1;
         ctrl_nx.wait_mode = dwee_pkg::WAIT_NONE;
         depth_nx          = depth;
         top_nx            = top;
         second_nx         = second;
         stk_we            = 1'b0;
         rf_we             = 1'b0;
         result            = '0;
         result.valid      = 1'b1;
         result.kind       = dwee_pkg::KIND_ERROR;
         result.error_code = fail_code;
      end
   end

endmodule
